// ===== rtl/abbp_pkg.sv =====
`default_nettype none
package abbp_pkg;

  // Width of the internal address arithmetic. It holds a rounded cursor plus a
  // full 32-bit size without wrapping.
  localparam int CALC_W = 34;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_SPM_BASE    = 2'd0;
  localparam logic [1:0] REG_SPM_LIMIT   = 2'd1;
  localparam logic [1:0] REG_DEFAULT_ALN = 2'd2;

  // Register reset values.
  localparam logic [31:0] SPM_BASE_RST    = 32'd0;
  localparam logic [31:0] SPM_LIMIT_RST   = 32'd65536;
  localparam logic [15:0] DEFAULT_ALN_RST = 16'd64;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ALIGN_BAD    = 3'd1;
  localparam logic [2:0] ST_END_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_CAPACITY     = 3'd3;
  localparam logic [2:0] ST_BAD_CONFIG   = 3'd4;
  localparam logic [2:0] ST_SKIPPED      = 3'd5;

  // Configuration seen by the placement unit.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
  } cfg_t;

  // A classified request waiting for placement.
  typedef struct packed {
    logic        first;
    logic [31:0] size;
    logic [15:0] align;
    logic        cfg_bad;
  } req_t;

  // A placed buffer waiting for its bank-line span.
  typedef struct packed {
    logic [31:0] offset;
    logic [32:0] biased;
    logic [15:0] align;
    logic [2:0]  status;
  } placed_t;

  // One finished result.
  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] align;
    logic [25:0] bank_begin;
    logic [26:0] bank_limit;
    logic [2:0]  status;
  } result_t;

  // True when a value does not fit in an address of the given width.
  function automatic logic addr_over(input logic [CALC_W-1:0] value,
                                     input int unsigned bits);
    logic over;
    begin
      if (bits >= CALC_W) begin
        over = 1'b0;
      end else begin
        over = (value >> bits) != '0;
      end
      return over;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/abbp_front.sv =====
`default_nettype none
module abbp_front #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 first_of_region,
  input  wire logic [31:0]          buffer_size,
  input  wire logic [15:0]          requested_alignment,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      req_valid,
  input  wire logic                 req_take,
  output abbp_pkg::req_t            req,
  output abbp_pkg::cfg_t            cfg
);

  logic [31:0]    spm_base;
  logic [31:0]    spm_limit;
  logic [15:0]    default_alignment;
  abbp_pkg::req_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           wr_en;
  abbp_pkg::req_t new_req;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spm_base          <= abbp_pkg::SPM_BASE_RST;
      spm_limit         <= abbp_pkg::SPM_LIMIT_RST;
      default_alignment <= abbp_pkg::DEFAULT_ALN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        abbp_pkg::REG_SPM_BASE:    spm_base <= cfg_data;
        abbp_pkg::REG_SPM_LIMIT:   spm_limit <= cfg_data;
        abbp_pkg::REG_DEFAULT_ALN: default_alignment <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg.base  = spm_base;
  assign cfg.limit = spm_limit;

  // Classify the incoming request: effective alignment and configuration check.
  always_comb begin
    new_req.first   = first_of_region;
    new_req.size    = buffer_size;
    new_req.align   = (default_alignment > requested_alignment) ?
                      default_alignment : requested_alignment;
    new_req.cfg_bad = (spm_limit <= spm_base) || (default_alignment == '0) ||
                      abbp_pkg::addr_over(abbp_pkg::CALC_W'(spm_limit), ADDR_BITS);
  end

  // Two-entry request queue between intake and placement.
  assign full      = count == 2'd2;
  assign req_valid = count != 2'd0;
  assign wr_en     = push && !full;
  assign req       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= new_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (req_take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, req_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/abbp_place.sv =====
`default_nettype none
module abbp_place #(
  parameter int ADDR_BITS       = 32,
  parameter int BANK_LINE_BYTES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_take,
  input  wire abbp_pkg::req_t     req,
  input  wire abbp_pkg::cfg_t     cfg,
  output logic                    placed_valid,
  input  wire logic               placed_ready,
  output abbp_pkg::placed_t       placed
);

  localparam int CW = abbp_pkg::CALC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [2:0]    state;
  logic          failed;
  logic [31:0]   cursor;
  logic [31:0]   start;
  logic [31:0]   dividend;
  logic [15:0]   rem;
  logic [4:0]    cnt;
  logic [31:0]   size;
  logic [15:0]   align;
  logic [CW-1:0] aligned;
  logic [CW-1:0] end_addr;
  logic [32:0]   biased_out;
  logic [2:0]    status;
  logic [16:0]   trial;
  logic          fits;
  logic [CW-1:0] biased;

  assign req_take     = (state == S_IDLE) && req_valid;
  assign placed_valid = state == S_SEND;

  assign placed.offset = aligned[31:0];
  assign placed.biased = biased_out;
  assign placed.align  = align;
  assign placed.status = status;

  // One restoring division step of the cursor by the alignment.
  assign trial  = {rem, dividend[31]};
  assign fits   = trial >= {1'b0, align};
  assign biased = end_addr + CW'(BANK_LINE_BYTES - 1);

  // Placement sequencer: remainder, round up, end address, range checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      failed <= 1'b0;
      cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            start    <= req.first ? cfg.base : cursor;
            dividend <= req.first ? cfg.base : cursor;
            rem      <= '0;
            cnt      <= '0;
            size     <= req.size;
            align    <= req.align;
            if (failed) begin
              status <= abbp_pkg::ST_SKIPPED;
              state  <= S_SEND;
            end else if (req.cfg_bad) begin
              status <= abbp_pkg::ST_BAD_CONFIG;
              failed <= 1'b1;
              state  <= S_SEND;
            end else begin
              if (req.first) begin
                cursor <= cfg.base;
              end
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem      <= fits ? 16'(trial - {1'b0, align}) : trial[15:0];
          dividend <= {dividend[30:0], 1'b0};
          cnt      <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          aligned <= (rem == '0) ? CW'(start) : CW'(start) + CW'(align - rem);
          state   <= S_END;
        end
        S_END: begin
          if (abbp_pkg::addr_over(aligned, ADDR_BITS)) begin
            status <= abbp_pkg::ST_ALIGN_BAD;
            failed <= 1'b1;
            state  <= S_SEND;
          end else begin
            end_addr <= aligned + CW'(size);
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_SEND;
          if (abbp_pkg::addr_over(end_addr, ADDR_BITS)) begin
            status <= abbp_pkg::ST_END_OVERFLOW;
            failed <= 1'b1;
          end else if ((aligned < CW'(cfg.base)) || (end_addr > CW'(cfg.limit))) begin
            status <= abbp_pkg::ST_CAPACITY;
            failed <= 1'b1;
          end else if (abbp_pkg::addr_over(biased, ADDR_BITS)) begin
            status <= abbp_pkg::ST_END_OVERFLOW;
            failed <= 1'b1;
          end else begin
            status     <= abbp_pkg::ST_OK;
            cursor     <= end_addr[31:0];
            biased_out <= biased[32:0];
          end
        end
        S_SEND: begin
          if (placed_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/abbp_bank.sv =====
`default_nettype none
module abbp_bank #(
  parameter int BANK_LINE_BYTES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               placed_valid,
  output logic                    placed_ready,
  input  wire abbp_pkg::placed_t  placed,
  output logic                    empty,
  input  wire logic               pop,
  output abbp_pkg::result_t       result
);

  // Dividends are at most 33 bits wide. The quotient by the line size is the
  // product with a rounded-up reciprocal, shifted right by SH bits.
  localparam int DW = 33;
  localparam int LB = $clog2(BANK_LINE_BYTES);
  localparam int SH = DW + LB;
  localparam int CW = 17;
  localparam int PW = DW + 2 * CW + LB;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(BANK_LINE_BYTES - 1)) /
                                  64'(BANK_LINE_BYTES);
  localparam logic [CW-1:0] RECIP_HI = RECIP[2*CW-1:CW];
  localparam logic [CW-1:0] RECIP_LO = RECIP[CW-1:0];

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HI   = 2'd1;
  localparam logic [1:0] S_LO   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]        state;
  logic [DW-1:0]     xa;
  logic [DW-1:0]     xb;
  logic [CW-1:0]     coef;
  logic [DW+CW-1:0]  prod_a;
  logic [DW+CW-1:0]  prod_b;
  logic [PW-1:0]     pa;
  logic [PW-1:0]     pb;
  logic [31:0]       offset;
  logic [15:0]       align;
  abbp_pkg::result_t queue [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              wr_en;
  abbp_pkg::result_t wr_data;
  logic              rd_en;
  logic              accept;

  assign placed_ready = (state == S_IDLE) && (count != 2'd2);
  assign accept       = placed_valid && placed_ready;

  // Start and end are multiplied side by side, upper reciprocal half first.
  assign coef   = (state == S_HI) ? RECIP_HI : RECIP_LO;
  assign prod_a = (DW+CW)'(xa) * (DW+CW)'(coef);
  assign prod_b = (DW+CW)'(xb) * (DW+CW)'(coef);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (placed.status == abbp_pkg::ST_OK)) begin
            xa     <= DW'(placed.offset);
            xb     <= placed.biased;
            offset <= placed.offset;
            align  <= placed.align;
            state  <= S_HI;
          end
        end
        S_HI: begin
          pa    <= PW'(prod_a);
          pb    <= PW'(prod_b);
          state <= S_LO;
        end
        S_LO: begin
          pa    <= (pa << CW) + PW'(prod_a);
          pb    <= (pb << CW) + PW'(prod_b);
          state <= S_WR;
        end
        S_WR: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Results enter the output queue: errors at once, placements when multiplied.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if ((state == S_IDLE) && accept && (placed.status != abbp_pkg::ST_OK)) begin
      wr_en          = 1'b1;
      wr_data.status = placed.status;
    end else if (state == S_WR) begin
      wr_en              = 1'b1;
      wr_data.offset     = offset;
      wr_data.align      = align;
      wr_data.bank_begin = pa[SH +: 26];
      wr_data.bank_limit = pb[SH +: 27];
      wr_data.status     = abbp_pkg::ST_OK;
    end
  end

  // Two-entry output queue; one waiting beat does not block the next placement, a full queue does.
  assign empty  = count == 2'd0;
  assign rd_en  = pop && !empty;
  assign result = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aligned_bump_buffer_placer_core.sv =====
// An accepted request passes the request queue, the 32-step remainder, the
// placement states and the line multiply (upper, then lower half) to its result beat.
// The placement unit takes no new request until it has sent the last one;
// skipped and invalid-configuration requests bypass the remainder unit.
// Reset: synchronous rst empties both queues, clears cursor and the failure
// flag, and loads the register reset values.
`default_nettype none
module aligned_bump_buffer_placer_core #(
  parameter int ADDR_BITS       = 32,
  parameter int BANK_LINE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        first_of_region,
  input  wire logic [31:0] buffer_size,
  input  wire logic [15:0] requested_alignment,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      placed_offset,
  output logic [15:0]      alignment_used,
  output logic [25:0]      bank_begin,
  output logic [26:0]      bank_limit,
  output logic [2:0]       status,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic              req_valid;
  logic              req_take;
  abbp_pkg::req_t    req;
  abbp_pkg::cfg_t    cfg;
  logic              placed_valid;
  logic              placed_ready;
  abbp_pkg::placed_t placed;
  abbp_pkg::result_t result;

  // Intake, configuration and request queue.
  abbp_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .first_of_region     (first_of_region),
    .buffer_size         (buffer_size),
    .requested_alignment (requested_alignment),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .req_valid           (req_valid),
    .req_take            (req_take),
    .req                 (req),
    .cfg                 (cfg)
  );

  // Cursor rounding and range checks.
  abbp_place #(
    .ADDR_BITS       (ADDR_BITS),
    .BANK_LINE_BYTES (BANK_LINE_BYTES)
  ) u_place (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_take     (req_take),
    .req          (req),
    .cfg          (cfg),
    .placed_valid (placed_valid),
    .placed_ready (placed_ready),
    .placed       (placed)
  );

  // Bank-line span and result queue.
  abbp_bank #(
    .BANK_LINE_BYTES (BANK_LINE_BYTES)
  ) u_bank (
    .clk          (clk),
    .rst          (rst),
    .placed_valid (placed_valid),
    .placed_ready (placed_ready),
    .placed       (placed),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

  assign placed_offset  = result.offset;
  assign alignment_used = result.align;
  assign bank_begin     = result.bank_begin;
  assign bank_limit     = result.bank_limit;
  assign status         = result.status;

endmodule
`default_nettype wire
